>>> src/acd_pkg.sv
// Shared types and constants for the acquisition command decoder and time-stamper.
// Used by every module of the block but the queue, and by its checker; depends on nothing.
package acd_pkg;

	localparam logic [7:0] CMD_SAMPLE_AB     = 8'd0;
	localparam logic [7:0] CMD_START_AB      = 8'd1;
	localparam logic [7:0] CMD_STOP_AB       = 8'd2;
	localparam logic [7:0] CMD_SAMPLE_A      = 8'd3;
	localparam logic [7:0] CMD_SAMPLE_B      = 8'd4;
	localparam logic [7:0] CMD_ZERO_AB       = 8'd5;
	localparam logic [7:0] CMD_SET_TYPE      = 8'd6;
	localparam logic [7:0] CMD_SET_AMOUNT    = 8'd7;
	localparam logic [7:0] CMD_SET_DILUTION  = 8'd8;
	localparam logic [7:0] CMD_SET_INJECTION = 8'd9;
	localparam logic [7:0] CMD_CH_FIRST      = 8'd10;
	localparam logic [7:0] CMD_MAX           = 8'd17;

	localparam logic [2:0] EVT_SAMPLE  = 3'd0;
	localparam logic [2:0] EVT_STARTED = 3'd1;
	localparam logic [2:0] EVT_STOPPED = 3'd2;
	localparam logic [2:0] EVT_ZERO    = 3'd3;
	localparam logic [2:0] EVT_PARAMS  = 3'd4;

	localparam logic [31:0] MAX_TYPE  = 32'd4;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
	localparam logic [47:0] POS_MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_MAG48 = 48'h8000_0000_0000;

	typedef enum logic [2:0] {
		ACT_SAMPLE,
		ACT_START,
		ACT_STOP,
		ACT_ZERO,
		ACT_TYPE,
		ACT_RATIO
	} act_kind_t;

	typedef enum logic [1:0] {
		RSEL_AMOUNT,
		RSEL_DILUTION,
		RSEL_INJECTION
	} rsel_t;

	typedef struct packed {
		act_kind_t   kind;
		logic [2:0]  ch;
		logic [31:0] raw;
	} act_t;

	typedef struct packed {
		act_t        first;
		act_t        second;
		logic        two;
		rsel_t       rsel;
		logic [31:0] num;
		logic [31:0] den;
	} op_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  channel;
		logic [47:0] retention_ms;
		logic [31:0] raw_value;
		logic [31:0] sample_type;
		logic [47:0] sample_amount;
		logic [47:0] dilution_factor;
		logic [47:0] injection_ratio;
		logic        params_valid;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DIV,
		BK_PARAM
	} back_state_t;

endpackage

>>> src/acd_fifo.sv
// Small register queue of generic width, used between the front and back parts
// and in front of the result ports. Depends on nothing.
module acd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> src/acd_front.sv
// Front part: accepts command items and turns each into one or two actions, or drops it.
// Depends on acd_pkg; feeds the operation queue.
module acd_front #(
	parameter int NUM_CHANNELS = 6
) (
	input  logic               push,
	output logic               full,
	input  logic [7:0]         cmd,
	input  logic signed [31:0] word_one,
	input  logic signed [31:0] word_two,
	input  logic               op_full,
	output logic               op_push,
	output acd_pkg::op_t       op
);

	acd_pkg::act_t a;
	acd_pkg::act_t b;
	logic          ea;
	logic          eb;
	logic          f1;
	logic          f2;
	logic [7:0]    off;
	logic [2:0]    xch;
	acd_pkg::rsel_t rsel;

	assign full = op_full;
	assign f1   = (word_one == 32'sd1);
	assign f2   = (word_two == 32'sd1);
	assign off  = cmd - acd_pkg::CMD_CH_FIRST;
	assign xch  = 3'd2 + off[3:1];

	always_comb begin
		a.kind = acd_pkg::ACT_SAMPLE;
		a.ch   = 3'd0;
		a.raw  = word_one;
		b.kind = acd_pkg::ACT_SAMPLE;
		b.ch   = 3'd1;
		b.raw  = word_two;
		ea     = 1'b0;
		eb     = 1'b0;
		rsel   = acd_pkg::RSEL_AMOUNT;
		unique case (cmd) inside
			acd_pkg::CMD_SAMPLE_AB: begin
				ea = 1'b1;
				eb = 1'b1;
			end
			acd_pkg::CMD_START_AB: begin
				a.kind = acd_pkg::ACT_START;
				b.kind = acd_pkg::ACT_START;
				ea     = f1;
				eb     = f2;
			end
			acd_pkg::CMD_STOP_AB: begin
				a.kind = acd_pkg::ACT_STOP;
				b.kind = acd_pkg::ACT_STOP;
				ea     = f1;
				eb     = f2;
			end
			acd_pkg::CMD_SAMPLE_A: begin
				ea = 1'b1;
			end
			acd_pkg::CMD_SAMPLE_B: begin
				eb = 1'b1;
			end
			acd_pkg::CMD_ZERO_AB: begin
				a.kind = acd_pkg::ACT_ZERO;
				b.kind = acd_pkg::ACT_ZERO;
				ea     = f1;
				eb     = f2;
			end
			acd_pkg::CMD_SET_TYPE: begin
				a.kind = acd_pkg::ACT_TYPE;
				ea     = 1'b1;
			end
			acd_pkg::CMD_SET_AMOUNT: begin
				a.kind = acd_pkg::ACT_RATIO;
				ea     = 1'b1;
			end
			acd_pkg::CMD_SET_DILUTION: begin
				a.kind = acd_pkg::ACT_RATIO;
				rsel   = acd_pkg::RSEL_DILUTION;
				ea     = 1'b1;
			end
			acd_pkg::CMD_SET_INJECTION: begin
				a.kind = acd_pkg::ACT_RATIO;
				rsel   = acd_pkg::RSEL_INJECTION;
				ea     = 1'b1;
			end
			[acd_pkg::CMD_CH_FIRST:acd_pkg::CMD_MAX]: begin
				a.ch = xch;
				b.ch = xch;
				if (int'(xch) < NUM_CHANNELS) begin
					if (!off[0]) begin
						ea = 1'b1;
					end else begin
						a.kind = acd_pkg::ACT_START;
						b.kind = acd_pkg::ACT_STOP;
						ea     = f1;
						eb     = f2;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		op.rsel = rsel;
		op.num  = word_one;
		op.den  = word_two;
		op.second = b;
		if (ea) begin
			op.first = a;
			op.two   = eb;
		end else begin
			op.first = b;
			op.two   = 1'b0;
		end
	end

	// Items that cause no result are taken and dropped here.
	assign op_push = push && !op_full && (ea || eb);

endmodule

>>> src/acd_div.sv
// Restoring divider for the signed fixed-point ratio, one quotient bit per cycle.
// Depends on acd_pkg for the saturation limits; used by the back part.
module acd_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quotient
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CTW = $clog2(NW + 1);

	logic [NW-1:0]  num_q;
	logic [31:0]    den_q;
	logic [31:0]    rem_q;
	logic [NW-1:0]  quo_q;
	logic [CTW-1:0] cnt_q;
	logic           fin_q;
	logic           done_q;
	logic           neg_q;
	logic           zero_q;
	logic [47:0]    quo_out_q;

	logic [31:0] num_mag;
	logic [31:0] den_mag;
	logic [32:0] rem_sh;
	logic        ge;
	logic [31:0] rem_nx;
	logic [63:0] qx;
	logic [47:0] pos_sat;
	logic [47:0] neg_mag;
	logic [47:0] sat;

	assign num_mag = num[31] ? 32'(-num) : num;
	assign den_mag = den[31] ? 32'(-den) : den;
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign ge      = (rem_sh >= {1'b0, den_q});
	assign rem_nx  = ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];

	assign qx      = 64'(quo_q);
	assign pos_sat = (qx > 64'(acd_pkg::POS_MAX48)) ? acd_pkg::POS_MAX48 : qx[47:0];
	assign neg_mag = (qx > 64'(acd_pkg::NEG_MAG48)) ? acd_pkg::NEG_MAG48 : qx[47:0];
	assign sat     = zero_q ? 48'd0 : (neg_q ? 48'd0 - neg_mag : pos_sat);

	assign done     = done_q;
	assign quotient = quo_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			if (start) begin
				cnt_q <= CTW'(NW);
				fin_q <= 1'b0;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CTW'(1);
				fin_q <= (cnt_q == CTW'(1));
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {num_mag, FRAC_BITS'(0)};
			den_q  <= den_mag;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= num[31] ^ den[31];
			zero_q <= (den == 32'd0);
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[NW-2:0], ge};
		end
		if (fin_q) begin
			quo_out_q <= sat;
		end
	end

endmodule

>>> src/acd_back.sv
// Back part: carries out queued actions, keeps the sample counts and autosampler
// parameters, and writes result items. Depends on acd_pkg and acd_div.
module acd_back #(
	parameter int NUM_CHANNELS = 6,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	input  logic          op_empty,
	input  acd_pkg::op_t  op_in,
	output logic          op_pop,
	input  logic          res_full,
	output logic          res_push,
	output acd_pkg::res_t res
);

	localparam int CW = $clog2(NUM_CHANNELS);
	localparam logic [47:0] ONE_FX = 48'd1 << FRAC_BITS;

	acd_pkg::back_state_t state_q;
	acd_pkg::back_state_t state_nx;
	acd_pkg::op_t         op_q;
	logic                 idx_q;
	logic [15:0]          period_q;
	logic [31:0]          count_q [NUM_CHANNELS];
	logic [31:0]          type_q;
	logic [47:0]          amount_q;
	logic [47:0]          dilution_q;
	logic [47:0]          injection_q;

	acd_pkg::act_t cur;
	logic          is_evt;
	logic          more;
	logic [CW-1:0] cidx;
	logic [31:0]   count_cur;
	logic [47:0]   retention;
	logic          div_start;
	logic          div_done;
	logic [47:0]   div_q;
	logic          valid;

	assign cur       = idx_q ? op_q.second : op_q.first;
	assign more      = !idx_q && op_q.two;
	assign cidx      = cur.ch[CW-1:0];
	assign count_cur = count_q[cidx];
	assign retention = {16'd0, count_cur} * {32'd0, period_q};
	assign valid     = (type_q <= acd_pkg::MAX_TYPE)
		&& !amount_q[47] && (amount_q != '0)
		&& !dilution_q[47] && (dilution_q != '0)
		&& !injection_q[47] && (injection_q != '0);

	always_comb begin
		case (cur.kind)
			acd_pkg::ACT_SAMPLE, acd_pkg::ACT_START,
			acd_pkg::ACT_STOP, acd_pkg::ACT_ZERO: is_evt = 1'b1;
			default: is_evt = 1'b0;
		endcase
	end

	acd_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (op_q.num),
		.den     (op_q.den),
		.done    (div_done),
		.quotient(div_q)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			acd_pkg::BK_IDLE: begin
				if (!op_empty) begin
					state_nx = acd_pkg::BK_RUN;
				end
			end
			acd_pkg::BK_RUN: begin
				if (is_evt) begin
					if (!res_full && !more) begin
						state_nx = acd_pkg::BK_IDLE;
					end
				end else if (cur.kind == acd_pkg::ACT_TYPE) begin
					state_nx = acd_pkg::BK_PARAM;
				end else begin
					state_nx = acd_pkg::BK_DIV;
				end
			end
			acd_pkg::BK_DIV: begin
				if (div_done) begin
					state_nx = acd_pkg::BK_PARAM;
				end
			end
			acd_pkg::BK_PARAM: begin
				if (!res_full) begin
					state_nx = acd_pkg::BK_IDLE;
				end
			end
			default: state_nx = acd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		op_pop    = 1'b0;
		res_push  = 1'b0;
		div_start = 1'b0;
		res       = '0;
		unique case (state_q)
			acd_pkg::BK_IDLE: begin
				op_pop = !op_empty;
			end
			acd_pkg::BK_RUN: begin
				res_push    = is_evt && !res_full;
				div_start   = (cur.kind == acd_pkg::ACT_RATIO);
				res.channel = cur.ch;
				res.last    = !more;
				case (cur.kind)
					acd_pkg::ACT_SAMPLE: begin
						res.event_kind   = acd_pkg::EVT_SAMPLE;
						res.retention_ms = retention;
						res.raw_value    = cur.raw;
					end
					acd_pkg::ACT_START: res.event_kind = acd_pkg::EVT_STARTED;
					acd_pkg::ACT_STOP:  res.event_kind = acd_pkg::EVT_STOPPED;
					default:            res.event_kind = acd_pkg::EVT_ZERO;
				endcase
			end
			acd_pkg::BK_DIV: begin
			end
			acd_pkg::BK_PARAM: begin
				res_push            = !res_full;
				res.event_kind      = acd_pkg::EVT_PARAMS;
				res.sample_type     = type_q;
				res.sample_amount   = amount_q;
				res.dilution_factor = dilution_q;
				res.injection_ratio = injection_q;
				res.params_valid    = valid;
				res.last            = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= acd_pkg::BK_IDLE;
			idx_q       <= 1'b0;
			period_q    <= 16'd1;
			type_q      <= '0;
			amount_q    <= ONE_FX;
			dilution_q  <= ONE_FX;
			injection_q <= ONE_FX;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				period_q <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
			end
			if (op_pop) begin
				idx_q <= 1'b0;
			end
			if (res_push && state_q == acd_pkg::BK_RUN) begin
				if (more) begin
					idx_q <= 1'b1;
				end
				if (cur.kind == acd_pkg::ACT_SAMPLE && count_cur != acd_pkg::COUNT_MAX) begin
					count_q[cidx] <= count_cur + 32'd1;
				end else if (cur.kind == acd_pkg::ACT_START) begin
					count_q[cidx] <= '0;
				end
			end
			if (state_q == acd_pkg::BK_RUN && cur.kind == acd_pkg::ACT_TYPE) begin
				type_q <= op_q.num;
			end
			if (state_q == acd_pkg::BK_DIV && div_done) begin
				case (op_q.rsel)
					acd_pkg::RSEL_AMOUNT:    amount_q    <= div_q;
					acd_pkg::RSEL_DILUTION:  dilution_q  <= div_q;
					default:                 injection_q <= div_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op_in;
		end
	end

endmodule

>>> src/acq_command_decoder_timestamper.sv
// Top level: front decoder, operation queue, back executor and result queue.
// Depends on acd_pkg, acd_fifo, acd_front and acd_back.
// An item's result goes through the operation queue and the back part into the result
// queue, and some items give a second one; an item without results is dropped at once.
// Ratio items wait in the back part for the bit-serial divider; others need no divider.
// Reset is asynchronous: it clears the counts and queues and restores the defaults.
module acq_command_decoder_timestamper #(
	parameter int NUM_CHANNELS = 6,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         cmd,
	input  logic signed [31:0] word_one,
	input  logic signed [31:0] word_two,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         event_kind,
	output logic [2:0]         channel,
	output logic [47:0]        retention_ms,
	output logic signed [31:0] raw_value,
	output logic signed [31:0] sample_type,
	output logic signed [47:0] sample_amount,
	output logic signed [47:0] dilution_factor,
	output logic signed [47:0] injection_ratio,
	output logic               params_valid,
	output logic               last
);

	localparam int OPW = $bits(acd_pkg::op_t);
	localparam int RESW = $bits(acd_pkg::res_t);

	acd_pkg::op_t  op_front;
	acd_pkg::op_t  op_back;
	acd_pkg::res_t res_back;
	acd_pkg::res_t res_out;
	logic          op_push;
	logic          op_full;
	logic          op_pop;
	logic          op_empty;
	logic [OPW-1:0] op_rd;
	logic          res_push;
	logic          res_full;
	logic [RESW-1:0] res_rd;

	acd_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.word_one(word_one),
		.word_two(word_two),
		.op_full (op_full),
		.op_push (op_push),
		.op      (op_front)
	);

	acd_fifo #(
		.WIDTH(OPW),
		.DEPTH(2)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_push),
		.wr_data(op_front),
		.full   (op_full),
		.rd_en  (op_pop),
		.rd_data(op_rd),
		.empty  (op_empty)
	);

	assign op_back = acd_pkg::op_t'(op_rd);

	acd_back #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.op_empty(op_empty),
		.op_in   (op_back),
		.op_pop  (op_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res     (res_back)
	);

	acd_fifo #(
		.WIDTH(RESW),
		.DEPTH(2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_back),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_rd),
		.empty  (empty)
	);

	assign res_out         = acd_pkg::res_t'(res_rd);
	assign event_kind      = res_out.event_kind;
	assign channel         = res_out.channel;
	assign retention_ms    = res_out.retention_ms;
	assign raw_value       = res_out.raw_value;
	assign sample_type     = res_out.sample_type;
	assign sample_amount   = res_out.sample_amount;
	assign dilution_factor = res_out.dilution_factor;
	assign injection_ratio = res_out.injection_ratio;
	assign params_valid    = res_out.params_valid;
	assign last            = res_out.last;

endmodule

>>> src/acd_checker.sv
// Port-level checker for the command decoder and time-stamper, with its bind.
// Depends on acd_pkg for the event codes.
module acd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [15:0]        cfg_data,
	input logic               push,
	input logic               full,
	input logic [7:0]         cmd,
	input logic signed [31:0] word_one,
	input logic signed [31:0] word_two,
	input logic               empty,
	input logic               pop,
	input logic [2:0]         event_kind,
	input logic [2:0]         channel,
	input logic [47:0]        retention_ms,
	input logic signed [31:0] raw_value,
	input logic signed [31:0] sample_type,
	input logic signed [47:0] sample_amount,
	input logic signed [47:0] dilution_factor,
	input logic signed [47:0] injection_ratio,
	input logic               params_valid,
	input logic               last
);

	// A waiting result item stays until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(retention_ms)
			&& $stable(last)))
		else $error("result item changed while waiting");

	a_param_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == acd_pkg::EVT_PARAMS) |-> (last && channel == 3'd0))
		else $error("parameter item not final or has a channel");

	a_non_param_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != acd_pkg::EVT_PARAMS) |->
			(sample_type == 32'sd0 && sample_amount == 48'sd0 && !params_valid))
		else $error("parameter fields set on a channel item");

	a_non_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != acd_pkg::EVT_SAMPLE) |->
			(retention_ms == 48'd0 && raw_value == 32'sd0))
		else $error("sample fields set on an event item");

endmodule

bind acq_command_decoder_timestamper acd_checker u_chk (.*);
